### src/nmea_cs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_cs_pkg
// Shared types, character codes and helpers for the NMEA checksum classifier.
// ----------------------------------------------------------------------------
package nmea_cs_pkg;

  localparam int unsigned POS_W = 8;

  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_P      = 8'h50;

  localparam logic [POS_W-1:0] POS_MAX     = '1;
  localparam logic [POS_W-1:0] POS_TYPE_LO = POS_W'(3);
  localparam logic [POS_W-1:0] POS_TYPE_HI = POS_W'(6);
  localparam logic [1:0]       DIGITS_SAT  = 2'd3;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_BODY = 2'd1,
    PH_HEX  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BAD_SUM    = 2'd0,
    KIND_WIND_POLAR = 2'd1,
    KIND_WIND_NMEA  = 2'd2,
    KIND_OTHER      = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic [1:0] digit_count;
    logic       overlong;
  } result_t;

  function automatic logic hex_valid(input logic [7:0] c);
    hex_valid = (c >= 8'h30 && c <= 8'h39) ||
                (c >= 8'h61 && c <= 8'h66) ||
                (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    hex_nibble = v[3:0];
  endfunction

endpackage

### src/nmea_cs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_cs_if
// Valid/ready channels: raw sentence bytes in, verdicts out.
// ----------------------------------------------------------------------------
interface nmea_cs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface nmea_cs_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] computed_sum;
  logic [7:0] received_sum;
  logic [1:0] digit_count;
  logic       overlong;

  modport source (output valid, output kind, output computed_sum, output received_sum,
                  output digit_count, output overlong, input ready);
  modport sink   (input valid, input kind, input computed_sum, input received_sum,
                  input digit_count, input overlong, output ready);
endinterface

### src/nmea_cs_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_cs_parser
// Sentence state machine: running XOR, offset tracking, hex checksum read
// and the verdict on the byte that ends a sentence.
// ----------------------------------------------------------------------------
module nmea_cs_parser
  import nmea_cs_pkg::*;
#(
  parameter int unsigned MAX_SENTENCE = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  localparam logic [POS_W-1:0] LIMIT = POS_W'(MAX_SENTENCE - 2);

  phase_e           phase_q, phase_d;
  logic [7:0]       xor_q, xor_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       type_q [4];
  logic [7:0]       type_d [4];
  logic [7:0]       hex_q, hex_d;
  logic [1:0]       dig_q, dig_d;
  logic             long_q, long_d;
  logic             match;
  logic [1:0]       type_idx;

  // offset 3..6 maps to slot 0..3
  assign type_idx = pos_q[1:0] + 2'd1;
  assign match    = (dig_q == 2'd1 || dig_q == 2'd2) && (hex_q == xor_q);

  always_comb begin
    phase_d     = phase_q;
    xor_d       = xor_q;
    pos_d       = pos_q;
    type_d      = type_q;
    hex_d       = hex_q;
    dig_d       = dig_q;
    long_d      = long_q;
    res_valid_o = 1'b0;

    if (step_i && (phase_q == PH_BODY || phase_q == PH_HEX)) begin
      if (pos_q >= POS_TYPE_LO && pos_q <= POS_TYPE_HI) begin
        type_d[type_idx] = byte_i;
      end
      if (pos_q != POS_MAX) begin
        pos_d = pos_q + POS_W'(1);
      end
    end

    if (step_i) begin
      case (phase_q)
        PH_WAIT: begin
          if (byte_i == CH_DOLLAR) begin
            phase_d = PH_BODY;
            xor_d   = '0;
            pos_d   = POS_W'(1);
            type_d  = '{default: 8'h00};
            hex_d   = '0;
            dig_d   = '0;
            long_d  = 1'b0;
          end
        end
        PH_BODY: begin
          if (byte_i == CH_STAR) begin
            phase_d = PH_HEX;
          end else begin
            if (pos_q > LIMIT) begin
              long_d = 1'b1;
            end
            xor_d = xor_q ^ byte_i;
          end
        end
        PH_HEX: begin
          if (hex_valid(byte_i)) begin
            hex_d = {hex_q[3:0], hex_nibble(byte_i)};
            if (dig_q != DIGITS_SAT) begin
              dig_d = dig_q + 2'd1;
            end
          end else begin
            res_valid_o = 1'b1;
            phase_d     = PH_WAIT;
          end
        end
        default: begin
          phase_d = PH_WAIT;
        end
      endcase
    end
  end

  // type check sees the ending byte too
  always_comb begin
    if (!match) begin
      res_o.kind = KIND_BAD_SUM;
    end else if (type_d[1] == CH_W && type_d[2] == CH_V && type_d[3] == CH_P) begin
      res_o.kind = KIND_WIND_POLAR;
    end else if (type_d[0] == CH_M && type_d[1] == CH_W && type_d[2] == CH_V) begin
      res_o.kind = KIND_WIND_NMEA;
    end else begin
      res_o.kind = KIND_OTHER;
    end
    res_o.computed_sum = xor_q;
    res_o.received_sum = hex_q;
    res_o.digit_count  = dig_q;
    res_o.overlong     = long_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      xor_q   <= '0;
      pos_q   <= '0;
      type_q  <= '{default: 8'h00};
      hex_q   <= '0;
      dig_q   <= '0;
      long_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      xor_q   <= xor_d;
      pos_q   <= pos_d;
      type_q  <= type_d;
      hex_q   <= hex_d;
      dig_q   <= dig_d;
      long_q  <= long_d;
    end
  end

endmodule

### src/nmea_cs_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_cs_outbuf
// Two-entry result buffer: output register plus skid slot.
// ----------------------------------------------------------------------------
module nmea_cs_outbuf
  import nmea_cs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  result_t  push_data_i,
  output logic     full_o,
  nmea_cs_result_if.source out_o
);

  result_t    mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;
  result_t    head;

  assign full_o    = (cnt_q == 2'd2);
  assign out_o.valid = (cnt_q != 2'd0);
  assign pop       = out_o.valid && out_o.ready;
  assign head      = mem_q[rd_q];

  assign out_o.kind         = head.kind;
  assign out_o.computed_sum = head.computed_sum;
  assign out_o.received_sum = head.received_sum;
  assign out_o.digit_count  = head.digit_count;
  assign out_o.overlong     = head.overlong;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

endmodule

### src/nmea_checksum_sentence_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_checksum_sentence_classifier_core
// NMEA-style sentence checksum check and type classification.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one raw stream byte per transfer (in_byte). Bytes before '$'
//           are dropped; the first non-hex byte after the '*' digits ends
//           the sentence.
//   out_o : one verdict per sentence (kind, computed_sum, received_sum,
//           digit_count, overlong), issued for the ending byte only.
// Throughput: one byte per cycle while the result buffer is not full. Each
//   byte is registered, then handled by the sentence state machine.
// Path: the ending byte is registered at the input, judged by the sentence
//   state machine, and its verdict written into the result buffer for out_o.
// Reset: the parser returns to waiting for '$' and the result buffer
//   empties; no clearing pass.
// Stall: results queue in a two-entry buffer (output register plus skid).
//   When it is full the input stage holds its byte and in_i.ready drops
//   until the receiver takes a result.
// ----------------------------------------------------------------------------
module nmea_checksum_sentence_classifier_core
  import nmea_cs_pkg::*;
#(
  parameter int unsigned MAX_SENTENCE = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  nmea_cs_byte_if.sink     in_i,
  nmea_cs_result_if.source out_o
);

  logic       vld_q;
  logic [7:0] byte_q;
  logic       full;
  logic       advance;
  logic       res_valid;
  result_t    res;

  assign advance  = vld_q && !full;
  assign in_i.ready = !vld_q || advance;

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.in_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  nmea_cs_parser #(
    .MAX_SENTENCE(MAX_SENTENCE)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .byte_i     (byte_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  nmea_cs_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .full_o     (full),
    .out_o      (out_o)
  );

endmodule

### tb/nmea_cs_verdict_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_cs_verdict_checker
// Watches the byte and verdict channels of the NMEA checksum classifier. It
// tracks the sentence parse for every accepted byte, queues the verdict each
// ending byte should produce, and compares every verdict transfer against the
// oldest queued one, field by field.
// ----------------------------------------------------------------------------
module nmea_cs_verdict_checker
  import nmea_cs_pkg::*;
#(
  parameter int unsigned MAX_SENTENCE = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  nmea_cs_byte_if          byte_mon_i,
  nmea_cs_result_if        verdict_mon_i,
  output int unsigned      err_count_o,
  output int unsigned      pending_o
);

  phase_e     phase;
  logic [7:0] xor_sum;
  logic [7:0] position;
  logic [7:0] type_chars [4];
  logic [7:0] hex_value;
  logic [1:0] hex_digits;
  logic       too_long;

  result_t    verdict_q [$];

  // -1 when the byte is not a hex digit
  function automatic int nibble_of(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return int'(c) - 'h30;
    if (c inside {[8'h61:8'h66]}) return int'(c) - 'h57;
    if (c inside {[8'h41:8'h46]}) return int'(c) - 'h37;
    return -1;
  endfunction

  // offsets 3..6 from the '$' hold the sentence type, wherever they land
  task automatic note_offset(input logic [7:0] c);
    if (position >= 8'd3 && position <= 8'd6) begin
      type_chars[2'(position - 8'd3)] = c;
    end
    if (position != 8'hFF) begin
      position++;
    end
  endtask

  task automatic parse_byte(input logic [7:0] c);
    int      d;
    logic    hit;
    result_t v;
    case (phase)
      PH_WAIT: begin
        if (c == CH_DOLLAR) begin
          xor_sum    = '0;
          position   = 8'd1;
          type_chars = '{default: '0};
          hex_value  = '0;
          hex_digits = '0;
          too_long   = 1'b0;
          phase      = PH_BODY;
        end
      end
      PH_BODY: begin
        if (c == CH_STAR) begin
          note_offset(c);
          phase = PH_HEX;
        end else begin
          if (position > MAX_SENTENCE - 2) begin
            too_long = 1'b1;
          end
          xor_sum ^= c;
          note_offset(c);
        end
      end
      default: begin
        d = nibble_of(c);
        note_offset(c);
        if (d >= 0) begin
          hex_value = {hex_value[3:0], 4'(d)};
          if (hex_digits != 2'd3) begin
            hex_digits++;
          end
        end else begin
          // no digits or more than two never match
          hit = (hex_digits == 2'd1 || hex_digits == 2'd2) && hex_value == xor_sum;
          if (!hit) begin
            v.kind = KIND_BAD_SUM;
          end else if (type_chars[1] == CH_W && type_chars[2] == CH_V &&
                       type_chars[3] == CH_P) begin
            v.kind = KIND_WIND_POLAR;
          end else if (type_chars[0] == CH_M && type_chars[1] == CH_W &&
                       type_chars[2] == CH_V) begin
            v.kind = KIND_WIND_NMEA;
          end else begin
            v.kind = KIND_OTHER;
          end
          v.computed_sum = xor_sum;
          v.received_sum = hex_value;
          v.digit_count  = hex_digits;
          v.overlong     = too_long;
          verdict_q.push_back(v);
          phase = PH_WAIT;
        end
      end
    endcase
  endtask

  task automatic check_verdict();
    result_t want;
    if (verdict_q.size() == 0) begin
      $error("unexpected verdict: kind %0d computed_sum %02h received_sum %02h",
             verdict_mon_i.kind, verdict_mon_i.computed_sum, verdict_mon_i.received_sum);
      err_count_o++;
    end else begin
      want = verdict_q.pop_front();
      if (verdict_mon_i.kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, verdict_mon_i.kind);
        err_count_o++;
      end
      if (verdict_mon_i.computed_sum !== want.computed_sum) begin
        $error("computed_sum: expected %02h, actual %02h",
               want.computed_sum, verdict_mon_i.computed_sum);
        err_count_o++;
      end
      if (verdict_mon_i.received_sum !== want.received_sum) begin
        $error("received_sum: expected %02h, actual %02h",
               want.received_sum, verdict_mon_i.received_sum);
        err_count_o++;
      end
      if (verdict_mon_i.digit_count !== want.digit_count) begin
        $error("digit_count: expected %0d, actual %0d",
               want.digit_count, verdict_mon_i.digit_count);
        err_count_o++;
      end
      if (verdict_mon_i.overlong !== want.overlong) begin
        $error("overlong: expected %0b, actual %0b", want.overlong, verdict_mon_i.overlong);
        err_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase       = PH_WAIT;
      xor_sum     = '0;
      position    = '0;
      type_chars  = '{default: '0};
      hex_value   = '0;
      hex_digits  = '0;
      too_long    = 1'b0;
      verdict_q.delete();
      err_count_o = 0;
      pending_o   = 0;
    end else begin
      // byte first: a verdict can never leave on its own ending byte's edge
      if (byte_mon_i.valid && byte_mon_i.ready) begin
        parse_byte(byte_mon_i.in_byte);
      end
      if (verdict_mon_i.valid && verdict_mon_i.ready) begin
        check_verdict();
      end
      pending_o = verdict_q.size();
    end
  end

endmodule

### tb/nmea_checksum_sentence_classifier_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_checksum_sentence_classifier_core_tb
// Streams NMEA-style sentences, junk and noise into the classifier with
// bursty byte transfers and a stalling verdict receiver, including one long
// hold-off that backs the block up. A checker beside the block predicts and
// compares every verdict.
// ----------------------------------------------------------------------------
module nmea_checksum_sentence_classifier_core_tb
  import nmea_cs_pkg::*;
();

  localparam int unsigned MAX_SENTENCE  = 128;
  localparam int unsigned RANDOM_BYTES  = 800;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_START    = 400;
  localparam int unsigned HOLD_LEN      = 300;
  localparam int unsigned DRAIN_CYCLES  = 10;

  typedef enum int {
    SHAPE_PLAIN,
    SHAPE_POLAR,
    SHAPE_NMEA
  } shape_e;

  typedef enum int {
    SUM_RIGHT,
    SUM_ONE_DIGIT,
    SUM_WRONG,
    SUM_NONE,
    SUM_LONG
  } sum_mode_e;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned err_count;
  int unsigned pending;
  int unsigned burst_left;
  int unsigned bytes_sent;
  int unsigned cycles;

  nmea_cs_byte_if   byte_ch ();
  nmea_cs_result_if verdict_ch ();

  nmea_checksum_sentence_classifier_core #(
    .MAX_SENTENCE(MAX_SENTENCE)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (byte_ch),
    .out_o (verdict_ch)
  );

  nmea_cs_verdict_checker #(
    .MAX_SENTENCE(MAX_SENTENCE)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .byte_mon_i   (byte_ch),
    .verdict_mon_i(verdict_ch),
    .err_count_o  (err_count),
    .pending_o    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  // one byte transfer; bursts of random length separated by idle gaps
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                              : $urandom_range(1, 12);
      @(negedge clk);
      byte_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    byte_ch.valid   <= 1'b1;
    byte_ch.in_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_sentence(input int body_len, input shape_e shape,
                               input sum_mode_e mode, input logic [7:0] ending);
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] wrong;
    int         i;
    sum = '0;
    send_byte(CH_DOLLAR);
    for (i = 0; i < body_len; i++) begin
      do begin
        b = $urandom_range(0, 1) ? 8'($urandom_range(8'h20, 8'h7E)) : 8'($urandom);
      end while (b == CH_STAR);
      // body index i sits at offset i + 1 from the '$'
      if (shape == SHAPE_POLAR) begin
        case (i)
          3: b = CH_W;
          4: b = CH_V;
          5: b = CH_P;
          default: ;
        endcase
      end else if (shape == SHAPE_NMEA) begin
        case (i)
          2: b = CH_M;
          3: b = CH_W;
          4: b = CH_V;
          default: ;
        endcase
      end
      sum ^= b;
      send_byte(b);
    end
    send_byte(CH_STAR);
    case (mode)
      SUM_RIGHT: begin
        send_byte(hex_char(sum[7:4]));
        send_byte(hex_char(sum[3:0]));
      end
      SUM_ONE_DIGIT: begin
        send_byte(hex_char(sum[3:0]));
      end
      SUM_WRONG: begin
        wrong = sum ^ 8'($urandom_range(1, 255));
        send_byte(hex_char(wrong[7:4]));
        send_byte(hex_char(wrong[3:0]));
      end
      SUM_LONG: begin
        // right value in the last two digits, still too many digits
        repeat ($urandom_range(1, 3)) send_byte(hex_char(4'($urandom)));
        send_byte(hex_char(sum[7:4]));
        send_byte(hex_char(sum[3:0]));
      end
      default: ;
    endcase
    send_byte(ending);
  endtask

  // verdict receiver: its own stall pattern plus one long hold-off
  initial begin : verdict_receiver
    int unsigned cyc;
    int unsigned mode;
    cyc  = 0;
    mode = 0;
    verdict_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
        verdict_ch.ready <= 1'b0;
      end else begin
        if (cyc % 50 == 0) begin
          mode = $urandom_range(0, 3);
        end
        case (mode)
          0: verdict_ch.ready <= 1'b1;
          1: verdict_ch.ready <= 1'($urandom_range(0, 1));
          2: verdict_ch.ready <= ($urandom_range(0, 3) == 0);
          default: verdict_ch.ready <= (cyc % 8 < 6);
        endcase
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("nmea_checksum_sentence_classifier_core_tb: errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned sentence_no;
    int unsigned pick;
    int          len;
    shape_e      shape;
    sum_mode_e   mode;
    logic [7:0]  b;
    byte_ch.valid   = 1'b0;
    byte_ch.in_byte = '0;
    rst_n      = 1'b0;
    burst_left = 0;
    bytes_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: junk extremes, both wind types, ending '$', missing and
    // extra digits, one-digit match, wrong sum
    send_byte(8'h00);
    send_byte(8'hFF);
    send_sentence(5, SHAPE_NMEA, SUM_RIGHT, 8'h0D);
    send_sentence(6, SHAPE_POLAR, SUM_RIGHT, CH_DOLLAR);
    send_byte(8'h41);
    send_sentence(0, SHAPE_PLAIN, SUM_NONE, 8'h2C);
    send_byte(CH_DOLLAR);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(CH_STAR);
    send_byte(8'h30);
    send_byte(8'h66);
    send_byte(8'h46);
    send_byte(8'h47);
    send_byte(CH_DOLLAR);
    send_byte(8'h01);
    send_byte(8'h0C);
    send_byte(CH_STAR);
    send_byte(8'h44);
    send_byte(8'h0A);
    send_sentence(7, SHAPE_PLAIN, SUM_WRONG, 8'h67);

    bytes_sent  = 0;
    sentence_no = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      sentence_no++;
      pick = $urandom_range(0, 99);
      if (sentence_no != 6 && sentence_no != 14 && pick < 8) begin
        // raw noise, may open or break a sentence anywhere
        repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(0, 2)) begin
          do b = 8'($urandom); while (b == CH_DOLLAR);
          send_byte(b);
        end
        if (sentence_no == 6) begin
          len = $urandom_range(127, 140);
        end else if (sentence_no == 14) begin
          len = $urandom_range(250, 270);  // offset can saturate
        end else if (pick < 20) begin
          len = $urandom_range(0, 5);
        end else begin
          len = $urandom_range(6, 40);
        end
        shape = (len >= 6) ? shape_e'($urandom_range(0, 2)) : SHAPE_PLAIN;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          mode = SUM_RIGHT;
        end else begin
          mode = sum_mode_e'(pick - 5);
        end
        case ($urandom_range(0, 3))
          0: b = 8'h0D;
          1: b = 8'h2C;
          default: begin
            do b = 8'($urandom);
            while (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
          end
        endcase
        send_sentence(len, shape, mode, b);
      end
    end

    @(negedge clk);
    byte_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("nmea_checksum_sentence_classifier_core_tb: clean");
    end else begin
      $display("nmea_checksum_sentence_classifier_core_tb: errors");
    end
    $finish;
  end

endmodule
